FILE: rtl/core/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define CSIPD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("csipd assertion failed");

// clocked assertion that also holds during reset
`define CSIPD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("csipd assertion failed");

`endif

FILE: rtl/core/csipd_pkg.sv
// types and constants of the presence detector core
`default_nettype none
package csipd_pkg;

    localparam int AMP_W      = 16;
    localparam int PH_W       = 15;
    localparam int TS_W       = 32;
    localparam int CONF_W     = 17;
    localparam int SCORE_W    = 32;
    localparam int IDX_W      = 9;
    localparam int ASUM_W     = 24;
    localparam int STEP_W     = 15;
    localparam int PSUM_W     = 24;
    localparam int DSUM_W     = 19;
    localparam int PCNT_W     = 3;
    localparam int N_W        = 9;
    localparam int S_W        = 24;
    localparam int Q_W        = 48;
    localparam int DIV_NW     = 57;
    localparam int DIV_DW     = 32;
    localparam int DIV_CW     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;

    localparam logic [15:0] PH_HALF = 16'd11520;
    localparam logic [16:0] PH_FULL = 17'd23040;
    localparam logic [CONF_W-1:0] CONF_ONE = 17'd65536;

    // reciprocal of ten, exact for 24-bit dividends
    localparam logic [24:0] DIV10_MUL = 25'd26843546;
    localparam int          DIV10_SH  = 28;

    localparam int NMARKS = 6;
    localparam logic [IDX_W-1:0] PAIR_MARK [NMARKS] = '{
        9'd5, 9'd20, 9'd40, 9'd60, 9'd80, 9'd100
    };

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONF_MIN  = 2'd1;

    // one finished frame, or a clear request, handed from front to back
    typedef struct packed {
        logic              clr;
        logic [ASUM_W-1:0] amp_sum;
        logic [IDX_W-1:0]  pos_cnt;
        logic [PSUM_W-1:0] step_sum;
        logic [IDX_W-1:0]  n_items;
        logic [DSUM_W-1:0] pair_sum;
        logic [PCNT_W-1:0] pair_cnt;
        logic [TS_W-1:0]   ts;
    } t_frame_rec;

endpackage
`default_nettype wire

FILE: rtl/core/csipd_in_if.sv
// subcarrier word channel
`default_nettype none
interface csipd_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [15:0]        amplitude;
    logic signed [14:0] phase;
    logic               last_subcarrier;
    logic [31:0]        timestamp;

    modport source (output valid, opcode, amplitude, phase, last_subcarrier, timestamp,
                    input ready);
    modport sink   (input valid, opcode, amplitude, phase, last_subcarrier, timestamp,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/core/csipd_out_if.sv
// detection result channel
`default_nettype none
interface csipd_out_if;
    logic        valid;
    logic        ready;
    logic        person_present;
    logic [16:0] confidence;
    logic [31:0] smoothed_score;
    logic [31:0] update_time;

    modport source (output valid, person_present, confidence, smoothed_score, update_time,
                    input ready);
    modport sink   (input valid, person_present, confidence, smoothed_score, update_time,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/core/csipd_ram.sv
// generic single-write, single-read ram with registered read
`default_nettype none
module csipd_ram #(
    parameter int W = 16,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/csipd_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module csipd_div import csipd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_go,
    input  wire logic [DIV_NW-1:0] i_num,
    input  wire logic [DIV_DW-1:0] i_den,
    output logic                   o_done,
    output logic      [DIV_NW-1:0] o_quo
);
    logic              r_busy;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW:0]   rem_sh;
    logic [DIV_DW:0]   rem_sub;
    logic              fits;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_NW-1]};
        fits    = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_NW - 1);
                r_rem  <= '0;
                r_den  <= i_den;
                r_quo  <= i_num;
            end else if (r_busy) begin
                r_rem <= fits ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
                r_quo <= {r_quo[DIV_NW-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_quo;
endmodule
`default_nettype wire

FILE: rtl/core/csipd_fifo.sv
// short queue of frame records between front and back
`default_nettype none
module csipd_fifo import csipd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  t_frame_rec      i_rec,
    input  wire logic       i_pop,
    output logic            o_full,
    output logic            o_empty,
    output t_frame_rec      o_rec
);
    t_frame_rec      r_buf [QDEPTH];
    logic [QPTR_W:0] r_wp;
    logic [QPTR_W:0] r_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) begin
                r_buf[r_wp[QPTR_W-1:0]] <= i_rec;
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    assign o_empty = r_wp == r_rp;
    assign o_full  = (r_wp[QPTR_W] != r_rp[QPTR_W]) &&
                     (r_wp[QPTR_W-1:0] == r_rp[QPTR_W-1:0]);
    assign o_rec   = r_buf[r_rp[QPTR_W-1:0]];
endmodule
`default_nettype wire

FILE: rtl/core/csipd_front.sv
// front end: per-subcarrier accumulation, one word a cycle while the queue is not full
`default_nettype none
module csipd_front import csipd_pkg::*; #(
    parameter int SUBCARRIERS = 128
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    csipd_in_if.sink   i_cmd,
    input  wire logic  i_full,
    output logic       o_push,
    output t_frame_rec o_rec
);
    logic [ASUM_W-1:0] r_amp_sum,  n_amp_sum;
    logic [IDX_W-1:0]  r_pos_cnt,  n_pos_cnt;
    logic [PSUM_W-1:0] r_step_sum, n_step_sum;
    logic [PH_W-1:0]   r_prev_ph,  n_prev_ph;
    logic [IDX_W-1:0]  r_idx,      n_idx;
    logic [DSUM_W-1:0] r_pair_sum, n_pair_sum;
    logic [PCNT_W-1:0] r_pair_cnt, n_pair_cnt;
    logic [AMP_W-1:0]  r_pair_amp, n_pair_amp;

    logic               acc;
    logic               take;
    logic signed [15:0] d;
    logic [15:0]        ad;
    logic [16:0]        wr;
    logic [STEP_W-1:0]  step;
    logic               mark_any;
    logic               mark_pair;
    logic [AMP_W-1:0]   pdiff;

    assign i_cmd.ready = !i_full;
    assign acc  = i_cmd.valid && !i_full;
    assign take = r_idx < IDX_W'(SUBCARRIERS);

    always_comb begin
        d    = {i_cmd.phase[PH_W-1], i_cmd.phase} - {r_prev_ph[PH_W-1], r_prev_ph};
        ad   = d[15] ? 16'(-d) : 16'(d);
        wr   = PH_FULL - {1'b0, ad};
        // wrapped step: go the short way round, never below zero
        if (ad > PH_HALF) begin
            step = wr[16] ? '0 : STEP_W'(wr);
        end else begin
            step = STEP_W'(ad);
        end
        mark_any  = 1'b0;
        mark_pair = 1'b0;
        for (int k = 0; k < NMARKS; k++) begin
            if (PAIR_MARK[k] == r_idx) begin
                mark_any = 1'b1;
                if (k > 0) begin
                    mark_pair = 1'b1;
                end
            end
        end
        pdiff = (i_cmd.amplitude > r_pair_amp) ? i_cmd.amplitude - r_pair_amp
                                               : r_pair_amp - i_cmd.amplitude;

        n_amp_sum  = r_amp_sum;
        n_pos_cnt  = r_pos_cnt;
        n_step_sum = r_step_sum;
        n_prev_ph  = r_prev_ph;
        n_idx      = r_idx;
        n_pair_sum = r_pair_sum;
        n_pair_cnt = r_pair_cnt;
        n_pair_amp = r_pair_amp;
        if (take) begin
            if (i_cmd.amplitude != '0) begin
                n_amp_sum = r_amp_sum + ASUM_W'(i_cmd.amplitude);
                n_pos_cnt = r_pos_cnt + 1'b1;
            end
            if (r_idx != '0) begin
                n_step_sum = r_step_sum + PSUM_W'(step);
            end
            n_prev_ph = i_cmd.phase;
            if (mark_pair) begin
                n_pair_sum = r_pair_sum + DSUM_W'(pdiff);
                n_pair_cnt = r_pair_cnt + 1'b1;
            end
            if (mark_any) begin
                n_pair_amp = i_cmd.amplitude;
            end
            n_idx = r_idx + 1'b1;
        end
    end

    assign o_push = acc && (i_cmd.opcode || i_cmd.last_subcarrier);

    always_comb begin
        o_rec.clr      = i_cmd.opcode;
        o_rec.amp_sum  = n_amp_sum;
        o_rec.pos_cnt  = n_pos_cnt;
        o_rec.step_sum = n_step_sum;
        o_rec.n_items  = n_idx;
        o_rec.pair_sum = n_pair_sum;
        o_rec.pair_cnt = n_pair_cnt;
        o_rec.ts       = i_cmd.timestamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (acc && (i_cmd.opcode || i_cmd.last_subcarrier))) begin
            r_amp_sum  <= '0;
            r_pos_cnt  <= '0;
            r_step_sum <= '0;
            r_prev_ph  <= '0;
            r_idx      <= '0;
            r_pair_sum <= '0;
            r_pair_cnt <= '0;
            r_pair_amp <= '0;
        end else if (acc) begin
            r_amp_sum  <= n_amp_sum;
            r_pos_cnt  <= n_pos_cnt;
            r_step_sum <= n_step_sum;
            r_prev_ph  <= n_prev_ph;
            r_idx      <= n_idx;
            r_pair_sum <= n_pair_sum;
            r_pair_cnt <= n_pair_cnt;
            r_pair_amp <= n_pair_amp;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/csipd_back.sv
// back end: per-frame sequencer over the history rings and the shared divider
`default_nettype none
module csipd_back import csipd_pkg::*; #(
    parameter int HISTORY_DEPTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_empty,
    input  t_frame_rec             i_rec,
    output logic                   o_pop,
    input  wire logic [31:0]       i_thr,
    input  wire logic [CONF_W-1:0] i_cmin,
    csipd_out_if.source            o_res
);
    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_MEAN, S_VAR0, S_VAR, S_VARM, S_VARD, S_VARW,
        S_PH, S_PHW, S_PR, S_PRW, S_SC, S_SCW, S_SM0, S_SM, S_SMD, S_SMW,
        S_CF, S_CFW, S_OUT
    } t_state;

    t_state             r_state;
    t_frame_rec         r_rec;
    logic [AW-1:0]      r_wp;
    logic [CW-1:0]      r_filled;
    logic [CW-1:0]      r_cnt;
    logic               r_pend;
    logic               r_pv;
    logic [HISTORY_DEPTH-1:0] r_sval;
    logic [S_W-1:0]     r_s;
    logic [Q_W-1:0]     r_q;
    logic [DIV_NW-1:0]  r_nq;
    logic [Q_W-1:0]     r_ss;
    logic [DIV_DW-1:0]  r_nn;
    logic [SCORE_W-1:0] r_a;
    logic [36:0]        r_p;
    logic [36:0]        r_c;
    logic [18:0]        r_qh;
    logic [3:0]         r_hr;
    logic [18:0]        r_xl;
    logic [DIV_NW-1:0]  r_ssum;
    logic [SCORE_W-1:0] r_smooth;
    logic               r_go;
    logic [DIV_NW-1:0]  r_num;
    logic [DIV_DW-1:0]  r_den;
    logic               r_ovld;
    logic               r_opres;
    logic [CONF_W-1:0]  r_oconf;
    logic [SCORE_W-1:0] r_oscore;
    logic [TS_W-1:0]    r_ots;

    logic               div_done;
    logic [DIV_NW-1:0]  div_quo;
    logic [SCORE_W-1:0] quo_sat;
    logic [AMP_W-1:0]   amp_rd;
    logic [SCORE_W-1:0] score_rd;
    logic               amp_we;
    logic               score_we;
    logic [AW-1:0]      raddr;
    logic [N_W-1:0]     n9;
    logic [37:0]        blend;
    logic [18:0]        hq;
    logic [3:0]         hr;
    logic [18:0]        lq;
    logic [37:0]        sc_q;
    logic [SCORE_W-1:0] sc_sat;
    logic               det;

    // floor(x / 10) by reciprocal multiplication
    function automatic logic [23:0] div10(input logic [23:0] x);
        logic [48:0] prod;
        prod = 49'(x) * 49'(DIV10_MUL);
        return 24'(prod >> DIV10_SH);
    endfunction

    csipd_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (r_go),
        .i_num  (r_num),
        .i_den  (r_den),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

    assign amp_we   = (r_state == S_MEAN) && div_done;
    assign score_we = (r_state == S_SCW);
    assign raddr    = r_cnt[AW-1:0];

    csipd_ram #(.W(AMP_W), .D(HISTORY_DEPTH)) u_amp_ram (
        .i_clk  (i_clk),
        .i_we   (amp_we),
        .i_waddr(r_wp),
        .i_wdata(div_quo[AMP_W-1:0]),
        .i_raddr(raddr),
        .o_rdata(amp_rd)
    );

    csipd_ram #(.W(SCORE_W), .D(HISTORY_DEPTH)) u_score_ram (
        .i_clk  (i_clk),
        .i_we   (score_we),
        .i_waddr(r_wp),
        .i_wdata(sc_sat),
        .i_raddr(raddr),
        .o_rdata(score_rd)
    );

    assign quo_sat = (div_quo[DIV_NW-1:SCORE_W] != '0) ? '1 : div_quo[SCORE_W-1:0];
    assign n9      = N_W'(r_filled);
    assign blend   = {r_a, 2'b00} + 38'(r_a) + 38'({r_p, 1'b0}) + 38'(r_p) + 38'({r_c, 1'b0});
    // score / 10 in two halves: upper 19 bits first, then remainder with the low 19 bits
    assign hq      = 19'(div10(24'(blend[37:19])));
    assign hr      = 4'(blend[37:19] - 19'(hq * 19'd10));
    assign lq      = 19'(div10(24'({r_hr, r_xl})));
    assign sc_q    = {r_qh, lq};
    assign sc_sat  = (sc_q[37:32] != '0) ? '1 : sc_q[31:0];
    assign det     = r_smooth > i_thr;
    assign o_pop   = (r_state == S_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wp     <= '0;
            r_filled <= '0;
            r_sval   <= '0;
            r_go     <= 1'b0;
            r_ovld   <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_go <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_rec <= i_rec;
                        if (i_rec.clr) begin
                            r_wp     <= '0;
                            r_filled <= '0;
                            r_sval   <= '0;
                        end else if (i_rec.pos_cnt != '0) begin
                            r_go    <= 1'b1;
                            r_num   <= DIV_NW'(i_rec.amp_sum);
                            r_den   <= DIV_DW'(i_rec.pos_cnt);
                            r_state <= S_MEAN;
                        end else begin
                            r_a     <= '0;
                            r_state <= S_PH;
                        end
                    end
                end
                S_MEAN: begin
                    if (div_done) begin
                        r_wp <= (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                        if (r_filled != CW'(HISTORY_DEPTH)) begin
                            r_filled <= r_filled + 1'b1;
                        end
                        r_state <= S_VAR0;
                    end
                end
                S_VAR0: begin
                    r_cnt  <= '0;
                    r_pend <= 1'b0;
                    r_s    <= '0;
                    r_q    <= '0;
                    if (r_filled < CW'(2)) begin
                        r_a     <= '0;
                        r_state <= S_PH;
                    end else begin
                        r_state <= S_VAR;
                    end
                end
                S_VAR: begin
                    r_pend <= r_cnt < r_filled;
                    if (r_cnt < r_filled) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_pend) begin
                        r_s <= r_s + S_W'(amp_rd);
                        r_q <= r_q + Q_W'(amp_rd * amp_rd);
                    end
                    if ((r_cnt == r_filled) && !r_pend) begin
                        r_state <= S_VARM;
                    end
                end
                S_VARM: begin
                    r_nq    <= DIV_NW'(n9 * r_q);
                    r_ss    <= Q_W'(r_s * r_s);
                    r_nn    <= DIV_DW'(n9 * n9);
                    r_state <= S_VARD;
                end
                S_VARD: begin
                    if (r_nq < DIV_NW'(r_ss)) begin
                        r_a     <= '0;
                        r_state <= S_PH;
                    end else begin
                        r_go    <= 1'b1;
                        r_num   <= r_nq - DIV_NW'(r_ss);
                        r_den   <= r_nn;
                        r_state <= S_VARW;
                    end
                end
                S_VARW: begin
                    if (div_done) begin
                        r_a     <= quo_sat;
                        r_state <= S_PH;
                    end
                end
                S_PH: begin
                    if (r_rec.n_items >= IDX_W'(2)) begin
                        r_go    <= 1'b1;
                        r_num   <= DIV_NW'({r_rec.step_sum, 10'b0});
                        r_den   <= DIV_DW'(r_rec.n_items - 1'b1);
                        r_state <= S_PHW;
                    end else begin
                        r_p     <= '0;
                        r_state <= S_PR;
                    end
                end
                S_PHW: begin
                    if (div_done) begin
                        r_p     <= div_quo[36:0];
                        r_state <= S_PR;
                    end
                end
                S_PR: begin
                    if (r_rec.pair_cnt != '0) begin
                        r_go    <= 1'b1;
                        r_num   <= DIV_NW'({r_rec.pair_sum, 8'b0});
                        r_den   <= DIV_DW'(r_rec.pair_cnt);
                        r_state <= S_PRW;
                    end else begin
                        r_c     <= '0;
                        r_state <= S_SC;
                    end
                end
                S_PRW: begin
                    if (div_done) begin
                        r_c     <= div_quo[36:0];
                        r_state <= S_SC;
                    end
                end
                S_SC: begin
                    r_qh    <= hq;
                    r_hr    <= hr;
                    r_xl    <= blend[18:0];
                    r_state <= S_SCW;
                end
                S_SCW: begin
                    r_sval[r_wp] <= 1'b1;
                    r_state      <= S_SM0;
                end
                S_SM0: begin
                    r_cnt   <= '0;
                    r_pend  <= 1'b0;
                    r_ssum  <= '0;
                    r_state <= S_SM;
                end
                S_SM: begin
                    r_pend <= r_cnt < r_filled;
                    r_pv   <= r_sval[raddr];
                    if (r_cnt < r_filled) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    // a slot never written since clear counts as zero
                    if (r_pend && r_pv) begin
                        r_ssum <= r_ssum + DIV_NW'(score_rd);
                    end
                    if ((r_cnt == r_filled) && !r_pend) begin
                        r_state <= S_SMD;
                    end
                end
                S_SMD: begin
                    if (r_filled == '0) begin
                        r_smooth <= '0;
                        r_state  <= S_CF;
                    end else begin
                        r_go    <= 1'b1;
                        r_num   <= r_ssum;
                        r_den   <= DIV_DW'(r_filled);
                        r_state <= S_SMW;
                    end
                end
                S_SMW: begin
                    if (div_done) begin
                        r_smooth <= div_quo[SCORE_W-1:0];
                        r_state  <= S_CF;
                    end
                end
                S_CF: begin
                    r_oscore <= r_smooth;
                    r_ots    <= r_rec.ts;
                    if (i_thr == '0) begin
                        r_oconf  <= det ? CONF_ONE : '0;
                        r_opres  <= det && ((det ? CONF_ONE : '0) > i_cmin);
                        r_ovld   <= 1'b1;
                        r_state  <= S_OUT;
                    end else begin
                        r_go    <= 1'b1;
                        r_num   <= det ? DIV_NW'({r_smooth, 15'b0})
                                       : DIV_NW'({i_thr - r_smooth, 16'b0});
                        r_den   <= i_thr;
                        r_state <= S_CFW;
                    end
                end
                S_CFW: begin
                    if (div_done) begin
                        if (det && (div_quo > DIV_NW'(CONF_ONE))) begin
                            r_oconf <= CONF_ONE;
                            r_opres <= CONF_ONE > i_cmin;
                        end else begin
                            r_oconf <= div_quo[CONF_W-1:0];
                            r_opres <= det && (div_quo[CONF_W-1:0] > i_cmin);
                        end
                        r_ovld  <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_res.ready) begin
                        r_ovld  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid          = r_ovld;
    assign o_res.person_present = r_opres;
    assign o_res.confidence     = r_oconf;
    assign o_res.smoothed_score = r_oscore;
    assign o_res.update_time    = r_ots;
endmodule
`default_nettype wire

FILE: rtl/core/csi_presence_detector_core.sv
// per frame the back end makes up to six passes of the shared divider and up to two ring
// walks over the history entries; the score scaling by ten is done in two halves
// throughput: one subcarrier word per cycle into the front while the queue is not full;
// a queue holds up to four finished frames while the back end works one frame at a time
// reset: synchronous, active low; rings read as empty through the fill count and
// per-slot valid bits, so no clearing pass is needed and words are taken at once
`default_nettype none
module csi_presence_detector_core import csipd_pkg::*; #(
    parameter int SUBCARRIERS   = 128,
    parameter int HISTORY_DEPTH = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    csipd_in_if.sink                   i_cmd,
    csipd_out_if.source                o_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic [31:0]       r_thr;
    logic [CONF_W-1:0] r_cmin;
    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;
    t_frame_rec        q_in;
    t_frame_rec        q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= 32'd65536;
            r_cmin <= 17'd32768;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD: r_thr  <= i_cfg_data;
                CFG_CONF_MIN:  r_cmin <= i_cfg_data[CONF_W-1:0];
                default: ;
            endcase
        end
    end

    csipd_front #(.SUBCARRIERS(SUBCARRIERS)) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (i_cmd),
        .i_full (q_full),
        .o_push (q_push),
        .o_rec  (q_in)
    );

    csipd_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_rec  (q_in),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_rec  (q_out)
    );

    csipd_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(q_empty),
        .i_rec  (q_out),
        .o_pop  (q_pop),
        .i_thr  (r_thr),
        .i_cmin (r_cmin),
        .o_res  (o_res)
    );
endmodule
`default_nettype wire

FILE: rtl/core/csipd_chk.sv
// port-level checker for the presence detector core, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module csipd_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_vld,
    input wire logic        i_rdy,
    input wire logic        i_pres,
    input wire logic [16:0] i_conf,
    input wire logic [31:0] i_score
);
    `CSIPD_ASSERT(a_hold, i_clk, i_rst_n, i_vld && !i_rdy |=> i_vld && $stable(i_score))
    `CSIPD_ASSERT(a_conf_max, i_clk, i_rst_n, i_vld |-> i_conf <= 17'd65536)
    `CSIPD_ASSERT(a_pres_score, i_clk, i_rst_n, i_vld && i_pres |-> i_score != 32'd0)
    `CSIPD_ASSERT(a_pres_conf, i_clk, i_rst_n, i_vld && i_pres |-> i_conf != 17'd0)
    `CSIPD_ASSERT_ALWAYS(a_rst, i_clk, $past(!i_rst_n) |-> !i_vld)
endmodule

bind csi_presence_detector_core csipd_chk u_chk (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_vld  (o_res.valid),
    .i_rdy  (o_res.ready),
    .i_pres (o_res.person_present),
    .i_conf (o_res.confidence),
    .i_score(o_res.smoothed_score)
);
`default_nettype wire
